/* hdl/prefix_count_tree_engine_top_assert.svh */
// assertion macros for the prefix count tree engine
`ifndef PREFIX_COUNT_TREE_ENGINE_TOP_ASSERT_SVH
`define PREFIX_COUNT_TREE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// expression holds at every rising clock edge out of reset
`define PCTE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define PCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCTE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define PCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/pcte_pkg.sv */
// shared constants and types for the prefix count tree engine
`default_nettype none

package pcte_pkg;

    localparam int MAX_RANKS  = 131072;
    localparam int TREE_NODES = 2 * MAX_RANKS;
    localparam int NODE_AW    = $clog2(TREE_NODES);
    localparam int RANK_W     = 17;
    localparam int CFG_W      = 18;
    localparam int COUNT_W    = 17;
    localparam int TOTAL_W    = 33;

    localparam logic [CFG_W-1:0]   RANK_COUNT_RESET = CFG_W'(131072);
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX        = {TOTAL_W{1'b1}};
    localparam logic [NODE_AW-1:0] ROOT_NODE        = NODE_AW'(1);
    localparam logic [NODE_AW-1:0] LAST_NODE        = NODE_AW'(TREE_NODES - 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] wa;
        logic [COUNT_W-1:0] wd;
        logic [NODE_AW-1:0] ra_a;
        logic [NODE_AW-1:0] ra_b;
    } t_ram_req;

endpackage

`default_nettype wire

/* hdl/pcte_node_ram.sv */
// node count memory, one write port and two registered read ports
`default_nettype none

module pcte_node_ram (
    input  wire logic                          i_clk,
    input  wire pcte_pkg::t_ram_req            i_req,
    output logic [pcte_pkg::COUNT_W-1:0]       o_rd_a,
    output logic [pcte_pkg::COUNT_W-1:0]       o_rd_b
);

    logic [pcte_pkg::COUNT_W-1:0] r_mem [pcte_pkg::TREE_NODES];
    logic [pcte_pkg::COUNT_W-1:0] r_rd_a;
    logic [pcte_pkg::COUNT_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        r_rd_a <= r_mem[i_req.ra_a];
        r_rd_b <= r_mem[i_req.ra_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

/* hdl/prefix_count_tree_engine_top.sv */
// top level: segment tree walk, clear sweep, stream ports and pair total
//
//  channel   dir  beat contents (low bits first)          handshake
//  s_axis    in   tdata: rank[16:0]; tuser: kind         tvalid/tready
//  m_axis    out  tdata: pairs_here[16:0], pair_total    tvalid/tready
//  cfg       in   i_cfg_wdata: rank_count[17:0]          i_cfg_we
//
// an insert beat is accepted in idle, then walks its tree path from the root one level at a time;
// a rank below n walks down to its leaf, a rank of n or more stops at the root (n = 0 skips the walk)
// each level of an in-range walk is one read-modify-write of the node memory, reads issued a level ahead
// a clear beat and reset both sweep all 262144 node words to zero, no input taken
// a clear result leaves after its sweep; a result waits in the output register while
// the next beat is accepted, and the walk holds only if that register is still full
`default_nettype none

`include "prefix_count_tree_engine_top_assert.svh"

module prefix_count_tree_engine_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pcte_pkg::CFG_W-1:0] i_cfg_wdata,   // rank_count
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [23:0]                s_axis_tdata,  // rank[16:0], zero pad
    input  wire logic                       s_axis_tuser,  // kind
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [55:0]                     m_axis_tdata   // pairs_here[16:0], pair_total[49:17]
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_HOLD  = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    localparam int CW = pcte_pkg::CFG_W;
    localparam int AW = pcte_pkg::NODE_AW;
    localparam int KW = pcte_pkg::COUNT_W;
    localparam int TW = pcte_pkg::TOTAL_W;

    t_state                   r_state;
    logic [CW-1:0]            r_rank_count;
    logic [pcte_pkg::RANK_W-1:0] r_rank;
    logic [CW-1:0]            r_lo;
    logic [CW-1:0]            r_hi;
    logic [AW-1:0]            r_k;
    logic [KW-1:0]            r_sum;
    logic [TW-1:0]            r_total;
    logic                     r_qry;
    logic                     r_ins;
    logic                     r_reply;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_out_valid;
    logic [KW-1:0]            r_out_here;
    logic [TW-1:0]            r_out_total;

    logic                     in_beat;
    logic                     in_kind;
    logic [pcte_pkg::RANK_W-1:0] in_rank;
    logic [CW-1:0]            span;
    logic                     in_ins;
    logic [CW-1:0]            rank_ext;
    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid;
    logic                     stop_q;
    logic                     go_left;
    logic [KW-1:0]            add_val;
    logic [KW:0]              sum_add;
    logic [KW-1:0]            n_sum;
    logic [TW:0]              total_add;
    logic [TW-1:0]            n_total;
    logic                     walk_done;
    logic [AW-1:0]            k_next;
    logic [KW-1:0]            rd_k;
    logic [KW-1:0]            rd_l;
    logic                     out_free;
    logic                     out_load;
    logic [KW-1:0]            load_here;
    logic [TW-1:0]            load_total;
    pcte_pkg::t_ram_req       ram_req;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign in_kind = s_axis_tuser;
    assign in_rank = s_axis_tdata[pcte_pkg::RANK_W-1:0];

    assign span    = (r_rank_count > CW'(pcte_pkg::MAX_RANKS)) ?
                     CW'(pcte_pkg::MAX_RANKS) : r_rank_count;
    assign in_ins  = ({1'b0, in_rank} < span);

    assign rank_ext = {1'b0, r_rank};
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign stop_q   = r_qry && (rank_ext >= r_hi);
    assign go_left  = (rank_ext <= mid);

    always_comb begin
        if (stop_q) begin
            add_val = rd_k;
        end else if (r_qry && !go_left) begin
            add_val = rd_l;
        end else begin
            add_val = '0;
        end
    end

    assign sum_add   = {1'b0, r_sum} + {1'b0, add_val};
    assign n_sum     = sum_add[KW] ? pcte_pkg::COUNT_MAX : sum_add[KW-1:0];
    assign total_add = {1'b0, r_total} + (TW+1)'(n_sum);
    assign n_total   = total_add[TW] ? pcte_pkg::TOTAL_MAX : total_add[TW-1:0];
    assign walk_done = r_ins ? (r_lo == r_hi) : stop_q;
    assign k_next    = {r_k[AW-2:0], ~go_left};

    assign out_free   = !r_out_valid || m_axis_tready;
    assign out_load   = out_free && (((r_state == S_WALK) && walk_done) ||
                                     (r_state == S_HOLD));
    assign load_here  = (r_state == S_WALK) ? n_sum : r_sum;
    assign load_total = (r_state == S_WALK) ? n_total : r_total;

    always_comb begin
        ram_req = '0;
        case (r_state)
            S_CLEAR: begin
                ram_req.we = 1'b1;
                ram_req.wa = r_clr_addr;
                ram_req.wd = '0;
            end
            S_WALK: begin
                ram_req.we   = r_ins;
                ram_req.wa   = r_k;
                ram_req.wd   = (rd_k == pcte_pkg::COUNT_MAX) ? rd_k : rd_k + KW'(1);
                ram_req.ra_a = k_next;
                ram_req.ra_b = {k_next[AW-2:0], 1'b0};
            end
            S_IDLE: begin
                ram_req.ra_a = pcte_pkg::ROOT_NODE;
                ram_req.ra_b = {pcte_pkg::ROOT_NODE[AW-2:0], 1'b0};
            end
            default: begin
                ram_req = '0;
            end
        endcase
    end

    pcte_node_ram u_node_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rd_a (rd_k),
        .o_rd_b (rd_l)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_rank_count <= pcte_pkg::RANK_COUNT_RESET;
            r_total      <= '0;
            r_sum        <= '0;
            r_qry        <= 1'b0;
            r_ins        <= 1'b0;
            r_reply      <= 1'b0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rank_count <= i_cfg_wdata;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_sum <= '0;
                        if (in_kind == pcte_pkg::KIND_CLEAR) begin
                            r_total    <= '0;
                            r_clr_addr <= '0;
                            r_reply    <= 1'b1;
                            r_state    <= S_CLEAR;
                        end else if (span == '0) begin
                            r_state <= S_HOLD;
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= span - CW'(1);
                            r_k     <= pcte_pkg::ROOT_NODE;
                            r_qry   <= 1'b1;
                            r_ins   <= in_ins;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_sum <= n_sum;
                    r_qry <= r_qry && !stop_q;
                    r_k   <= k_next;
                    if (go_left) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid + CW'(1);
                    end
                    if (walk_done) begin
                        r_total <= n_total;
                        r_state <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == pcte_pkg::LAST_NODE) begin
                        r_state <= r_reply ? S_HOLD : S_IDLE;
                        r_reply <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_rank <= in_rank;
        end
        if (out_load) begin
            r_out_here  <= load_here;
            r_out_total <= load_total;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_total, r_out_here};

    `PCTE_ASSERT_ALWAYS(a_walk_range, i_clk, i_rst_n, (r_state != S_WALK) || (r_lo <= r_hi), "walk range inverted")
    `PCTE_ASSERT_ALWAYS(a_rank_on_path, i_clk, i_rst_n, (r_state != S_WALK) || !r_ins || ((rank_ext >= r_lo) && (rank_ext <= r_hi)), "insert rank left its path")
    `PCTE_ASSERT_NEXT(a_clear_start, i_clk, i_rst_n, in_beat && (in_kind == pcte_pkg::KIND_CLEAR), (r_state == S_CLEAR) && (r_clr_addr == '0) && (r_total == '0), "clear did not start sweep")
    `PCTE_ASSERT_NEXT(a_sum_grows, i_clk, i_rst_n, (r_state == S_WALK) && !walk_done, (r_state == S_WALK) && (r_sum >= $past(r_sum)), "walk sum shrank")

endmodule

`default_nettype wire
